// ----- rtl/dbgo_pkg.sv -----
package dbgo_pkg;

  // Widths of the code bytes, the glyph index, the glyph size and the offset.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned IndexW  = 16;
  localparam int unsigned SizeW   = 8;
  localparam int unsigned BaseW   = 32;
  localparam int unsigned ProdW   = IndexW + SizeW;
  localparam int unsigned OffsetW = 33;
  localparam int unsigned CfgW    = 32;

  // Configuration register indexes.
  localparam logic RegGlyphBytes = 1'b0;
  localparam logic RegLangOffset = 1'b1;

  // Encoding modes.
  localparam logic ModeUnicode = 1'b0;
  localparam logic ModeLocal   = 1'b1;

  // Row lengths of the zones.
  localparam logic [IndexW-1:0] UserRowLen  = 16'd94;
  localparam logic [IndexW-1:0] ZoneThreeRowLen = 16'd97;
  localparam logic [IndexW-1:0] ZoneFiveRowLen  = 16'd32;
  localparam logic [IndexW-1:0] MainRowLen  = 16'hC0;

  // First index of each user zone after the first one.
  localparam logic [IndexW-1:0] ZoneTwoBase   = 16'd564;
  localparam logic [IndexW-1:0] ZoneThreeBase = 16'd564 + 16'd658;
  localparam logic [IndexW-1:0] ZoneFiveBase  = 16'd564 + 16'd658 + 16'd679;

  // Full-width question mark, code A3 BF of the main table.
  localparam logic [IndexW-1:0] QmarkIndex =
      (16'hA3 - 16'h81) * MainRowLen + (16'hBF - 16'h40);

  // Byte limits of the zones.
  localparam logic [ByteW-1:0] ZoneOneHiLo   = 8'hAA;
  localparam logic [ByteW-1:0] ZoneOneHiHi   = 8'hAF;
  localparam logic [ByteW-1:0] ZoneTwoHiLo   = 8'hF8;
  localparam logic [ByteW-1:0] ZoneTwoHiHi   = 8'hFE;
  localparam logic [ByteW-1:0] ZoneThreeHiLo = 8'hA1;
  localparam logic [ByteW-1:0] ZoneThreeHiHi = 8'hA7;
  localparam logic [ByteW-1:0] UserLoFirst   = 8'hA1;
  localparam logic [ByteW-1:0] MainLoFirst   = 8'h40;
  localparam logic [ByteW-1:0] ZoneFiveLoFirst = 8'h20;
  localparam logic [ByteW-1:0] LeadFirst     = 8'h81;
  localparam logic [ByteW-1:0] LeadLast      = 8'hFE;

  // One classified word as it travels from the front to the back.
  typedef struct packed {
    logic [IndexW-1:0] index;
    logic              from_file;
  } dbgo_word_t;

  // Queue status seen by the top level and the back end.
  typedef struct packed {
    logic full;
    logic valid;
  } dbgo_qstat_t;

endpackage

// ----- rtl/double_byte_glyph_offset.sv -----
// Glyph address unit for two-byte character codes.
//
// A code word is pushed on push_i while full_o is low: mode_i selects
// Unicode (the index is the 16-bit code) or local double-byte coding, where
// the bytes are sorted into four user-defined zones (glyph in the user font
// file) or the main table (reserved area); unknown codes fall back to the
// full-width question mark. The result word carries the byte offset
// index * glyph_bytes + language_offset and the user-file flag. Results are
// read like a queue: a word is on the outputs while empty_o is low and is
// taken by pop_i.
// Configuration is a plain write port: cfg_idx_i 0 is glyph_bytes (bits 7:0
// of cfg_data_i), 1 is language_offset. Write it only while the unit is idle.
// Words pass the queue, then the two-stage multiply-add back end (product
// and output registers); one word per cycle flows while pop_i keeps up.
// When the reader stalls, the back end holds its words and the short input
// queue (QueueDepth words) fills, then full_o rises. Reset empties the
// queue and the pipeline and loads glyph_bytes = 32 and language_offset = 0.
module double_byte_glyph_offset #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [dbgo_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic                         mode_i,
  input  logic [dbgo_pkg::ByteW-1:0]   high_byte_i,
  input  logic [dbgo_pkg::ByteW-1:0]   low_byte_i,
  output logic                         empty_o,
  input  logic                         pop_i,
  output logic [dbgo_pkg::OffsetW-1:0] glyph_offset_o,
  output logic                         from_user_file_o
);
  import dbgo_pkg::*;

  logic [SizeW-1:0] glyph_bytes_q;
  logic [BaseW-1:0] lang_offset_q;
  dbgo_word_t       front_word, queue_word;
  dbgo_qstat_t      qstat;
  logic             push_en, take;
  logic             out_valid;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_bytes_q <= 8'd32;
      lang_offset_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegGlyphBytes: glyph_bytes_q <= cfg_data_i[SizeW-1:0];
        RegLangOffset: lang_offset_q <= cfg_data_i[BaseW-1:0];
        default: ;
      endcase
    end
  end

  // The front end classifies the code in the cycle it arrives.
  dbgo_front u_front (
    .mode_i      (mode_i),
    .high_byte_i (high_byte_i),
    .low_byte_i  (low_byte_i),
    .word_o      (front_word)
  );

  assign full_o  = qstat.full;
  assign push_en = push_i && !qstat.full;

  dbgo_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push_en),
    .wr_word_i (front_word),
    .rd_en_i   (take),
    .rd_word_o (queue_word),
    .stat_o    (qstat)
  );

  // The back end multiplies by the glyph size and adds the language base.
  dbgo_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .glyph_bytes_i    (glyph_bytes_q),
    .lang_offset_i    (lang_offset_q),
    .word_valid_i     (qstat.valid),
    .word_i           (queue_word),
    .word_take_o      (take),
    .out_valid_o      (out_valid),
    .out_pop_i        (pop_i),
    .glyph_offset_o   (glyph_offset_o),
    .from_user_file_o (from_user_file_o)
  );

  assign empty_o = !out_valid;

endmodule

// ----- rtl/dbgo_front.sv -----
module dbgo_front (
  input  logic                        mode_i,
  input  logic [dbgo_pkg::ByteW-1:0]  high_byte_i,
  input  logic [dbgo_pkg::ByteW-1:0]  low_byte_i,
  output dbgo_pkg::dbgo_word_t        word_o
);
  import dbgo_pkg::*;

  logic in_one, in_two, in_three, in_five, in_main;
  logic [IndexW-1:0] idx_one, idx_two, idx_three, idx_five, idx_main;

  // Zone tests, in priority order.
  assign in_one   = (high_byte_i >= ZoneOneHiLo) && (high_byte_i <= ZoneOneHiHi) &&
                    (low_byte_i >= UserLoFirst);
  assign in_two   = (high_byte_i >= ZoneTwoHiLo) && (high_byte_i <= ZoneTwoHiHi) &&
                    (low_byte_i >= UserLoFirst);
  assign in_three = (high_byte_i >= ZoneThreeHiLo) && (high_byte_i <= ZoneThreeHiHi) &&
                    (low_byte_i >= MainLoFirst) && (low_byte_i < UserLoFirst);
  assign in_five  = (high_byte_i >= LeadFirst) && (low_byte_i >= ZoneFiveLoFirst) &&
                    (low_byte_i < MainLoFirst);
  assign in_main  = (high_byte_i >= LeadFirst) && (high_byte_i <= LeadLast) &&
                    (low_byte_i >= MainLoFirst);

  // Row times row length plus column, each only meaningful inside its zone.
  assign idx_one   = IndexW'(high_byte_i - ZoneOneHiLo) * UserRowLen +
                     IndexW'(low_byte_i - UserLoFirst);
  assign idx_two   = IndexW'(high_byte_i - ZoneTwoHiLo) * UserRowLen +
                     IndexW'(low_byte_i - UserLoFirst) + ZoneTwoBase;
  assign idx_three = IndexW'(high_byte_i - ZoneThreeHiLo) * ZoneThreeRowLen +
                     IndexW'(low_byte_i - MainLoFirst) + ZoneThreeBase;
  assign idx_five  = IndexW'(high_byte_i - LeadFirst) * ZoneFiveRowLen +
                     IndexW'(low_byte_i - ZoneFiveLoFirst) + ZoneFiveBase;
  assign idx_main  = IndexW'(high_byte_i - LeadFirst) * MainRowLen +
                     IndexW'(low_byte_i - MainLoFirst);

  always_comb begin
    word_o.from_file = 1'b0;
    if (mode_i == ModeUnicode) begin
      word_o.index = {high_byte_i, low_byte_i};
    end else if (in_one) begin
      word_o.index     = idx_one;
      word_o.from_file = 1'b1;
    end else if (in_two) begin
      word_o.index     = idx_two;
      word_o.from_file = 1'b1;
    end else if (in_three) begin
      word_o.index     = idx_three;
      word_o.from_file = 1'b1;
    end else if (in_five) begin
      word_o.index     = idx_five;
      word_o.from_file = 1'b1;
    end else if (in_main) begin
      word_o.index = idx_main;
    end else begin
      word_o.index = QmarkIndex;
    end
  end

endmodule

// ----- rtl/dbgo_queue.sv -----
module dbgo_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_en_i,
  input  dbgo_pkg::dbgo_word_t   wr_word_i,
  input  logic                   rd_en_i,
  output dbgo_pkg::dbgo_word_t   rd_word_o,
  output dbgo_pkg::dbgo_qstat_t  stat_o
);
  import dbgo_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  dbgo_word_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == FullCnt);
  assign stat_o.valid = (cnt_q != '0);
  assign rd_word_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en_i && !rd_en_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en_i && rd_en_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_word_i;
    end
  end

  // The fill count never runs past the depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue count exceeds depth");

  // Nothing is written into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.full |-> !wr_en_i)
    else $error("write into full queue");

  // Nothing is read from an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat_o.valid |-> !rd_en_i)
    else $error("read from empty queue");

  // The count follows the pointers: equal pointers mean empty or full.
  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q == rd_ptr_q) |-> (cnt_q == '0 || cnt_q == FullCnt))
    else $error("queue pointers and count disagree");

endmodule

// ----- rtl/dbgo_back.sv -----
module dbgo_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [dbgo_pkg::SizeW-1:0]   glyph_bytes_i,
  input  logic [dbgo_pkg::BaseW-1:0]   lang_offset_i,
  input  logic                         word_valid_i,
  input  dbgo_pkg::dbgo_word_t         word_i,
  output logic                         word_take_o,
  output logic                         out_valid_o,
  input  logic                         out_pop_i,
  output logic [dbgo_pkg::OffsetW-1:0] glyph_offset_o,
  output logic                         from_user_file_o
);
  import dbgo_pkg::*;

  logic               prod_valid_q, out_valid_q;
  logic [ProdW-1:0]   prod_q;
  logic               prod_file_q;
  logic [OffsetW-1:0] offset_q;
  logic               out_file_q;
  logic               out_ready, prod_ready;

  // A stage advances when the one after it is empty or draining.
  assign out_ready   = !out_valid_q || out_pop_i;
  assign prod_ready  = !prod_valid_q || out_ready;
  assign word_take_o = word_valid_i && prod_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid_q <= word_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= prod_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_take_o) begin
      prod_q      <= ProdW'(word_i.index) * ProdW'(glyph_bytes_i);
      prod_file_q <= word_i.from_file;
    end
    if (out_ready && prod_valid_q) begin
      offset_q   <= OffsetW'(prod_q) + OffsetW'(lang_offset_i);
      out_file_q <= prod_file_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign glyph_offset_o   = offset_q;
  assign from_user_file_o = out_file_q;

endmodule
